// File: sv/cgff_pkg.sv
// cgff_pkg: sizes, codes, types and helpers for the coarse grid flood fill
// depends on nothing; imported by cgff_front, cgff_back and coarse_grid_flood_fill
package cgff_pkg;

    localparam int COARSE_DIM  = 64;
    localparam int MAX_SCALE   = 4;
    localparam int STACK_DEPTH = 4096;

    localparam int FINE_DIM    = COARSE_DIM * MAX_SCALE;
    localparam int FINE_DEPTH  = FINE_DIM * FINE_DIM;
    localparam int VIS_DEPTH   = COARSE_DIM * COARSE_DIM;
    localparam int CX_W        = $clog2(COARSE_DIM);
    localparam int FX_W        = $clog2(FINE_DIM);
    localparam int FA_W        = $clog2(FINE_DEPTH);
    localparam int VA_W        = $clog2(VIS_DEPTH);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DIM_W       = $clog2(COARSE_DIM + 1);
    localparam int SC_W        = $clog2(MAX_SCALE + 1);
    localparam int CNT_W       = $clog2(MAX_SCALE * MAX_SCALE + 1);

    localparam int MODE_W      = 2;
    localparam int POS_W       = 8;
    localparam int COST_W      = 8;
    localparam int STAT_W      = 2;
    localparam int CLS_W       = 2;
    localparam int EXP_W       = 12;
    localparam int SCALE_W     = 3;
    localparam int WH_W        = 7;
    localparam int HOME_W      = 6;
    localparam int CIDX_W      = 3;
    localparam int CDATA_W     = 12;
    localparam int COORD_W     = ((CX_W + 1 > POS_W) ? CX_W + 1 : POS_W) + 1;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [CLS_W-1:0] CLS_FREE  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_OCC   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_UNK   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_OTHER = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_HOME_OCC = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LIMIT    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

    localparam logic [COST_W-1:0] COST_FREE = 8'd0;
    localparam logic [COST_W-1:0] COST_OCC  = 8'd254;
    localparam logic [COST_W-1:0] COST_UNK  = 8'd255;

    localparam logic [CIDX_W-1:0] CFG_SCALE   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_HOME_X  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_HOME_Y  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MAX_EXP = 3'd5;

    localparam logic [SCALE_W-1:0] SCALE_RST   = 3'd2;
    localparam logic [WH_W-1:0]    WH_RST      = 7'd64;
    localparam logic [EXP_W-1:0]   MAX_EXP_RST = 12'd1000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [CLS_W-1:0]  fcls;
        logic              in_range;
    } cmd_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [WH_W-1:0]    width;
        logic [WH_W-1:0]    height;
        logic [HOME_W-1:0]  home_x;
        logic [HOME_W-1:0]  home_y;
        logic [EXP_W-1:0]   max_exp;
    } cfg_t;

    // majority threshold round(0.8 * s * s)
    function automatic logic [CNT_W-1:0] thr_of(input logic [SC_W-1:0] s);
        logic [CNT_W-1:0] t;
        int n;
        n = int'(s) * int'(s);
        t = '0;
        for (int k = 0; k <= MAX_SCALE * MAX_SCALE; k++)
        begin
            if (10 * k <= 8 * n + 5)
            begin
                t = CNT_W'(k);
            end
        end
        return t;
    endfunction

endpackage

// File: sv/cgff_ram.sv
// cgff_ram: generic simple dual-port ram, one write and one registered read
// depends on nothing
module cgff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cgff_front.sv
// cgff_front: accepts input transactions, decodes them and queues commands
// depends on cgff_pkg
module cgff_front
    import cgff_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clearing,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_y,
    input  logic [COST_W-1:0] cost,
    output logic              q_valid,
    input  logic              q_ready,
    output cmd_t              q_cmd
);

    cmd_t       q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    cmd_t       dec;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec.mode     = mode;
        dec.px       = pos_x;
        dec.py       = pos_y;
        dec.in_range = (int'(pos_x) < FINE_DIM) && (int'(pos_y) < FINE_DIM);
        priority if (cost == COST_FREE)
        begin
            dec.fcls = CLS_FREE;
        end
        else if (cost == COST_OCC)
        begin
            dec.fcls = CLS_OCC;
        end
        else if (cost == COST_UNK)
        begin
            dec.fcls = CLS_UNK;
        end
        else
        begin
            dec.fcls = CLS_OTHER;
        end
    end

    assign in_ready = !clearing && (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = q_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

endmodule

// File: sv/cgff_back.sv
// cgff_back: carries out queued commands: fine grid writes, coarse queries, flood fill runs
// depends on cgff_pkg and cgff_ram
module cgff_back
    import cgff_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_t              q_cmd,
    output logic              clearing,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic              reachable,
    output logic [CLS_W-1:0]  coarse_class,
    output logic [EXP_W-1:0]  expanded
);

    localparam logic [3:0] S_RCLR   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_QCLS   = 4'd2;
    localparam logic [3:0] S_QWAIT  = 4'd3;
    localparam logic [3:0] S_VCLR   = 4'd4;
    localparam logic [3:0] S_HSTART = 4'd5;
    localparam logic [3:0] S_HWAIT  = 4'd6;
    localparam logic [3:0] S_NSTART = 4'd7;
    localparam logic [3:0] S_NWAIT  = 4'd8;
    localparam logic [3:0] S_NVIS   = 4'd9;
    localparam logic [3:0] S_POP    = 4'd10;
    localparam logic [3:0] S_PDATA  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam logic [1:0] CU_IDLE  = 2'd0;
    localparam logic [1:0] CU_SCAN  = 2'd1;
    localparam logic [1:0] CU_DRAIN = 2'd2;
    localparam logic [1:0] CU_OUT   = 2'd3;

    function automatic logic in_map_f(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [DIM_W-1:0] w,
                                      input logic [DIM_W-1:0] h);
        return !x[COORD_W-1] && !y[COORD_W-1]
            && (x[COORD_W-2:0] < (COORD_W-1)'(w))
            && (y[COORD_W-2:0] < (COORD_W-1)'(h));
    endfunction

    // effective configuration
    logic [SC_W-1:0]  eff_s;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [CNT_W-1:0] thr_reg;

    // main sequencer
    logic [3:0]         st_reg, st_next;
    logic [FA_W-1:0]    clr_reg, clr_next;
    logic [POS_W-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [CLS_W-1:0]   home_cls_reg, home_cls_next;
    logic [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic [STAT_W-1:0]  last_st_reg, last_st_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               reach_reg, reach_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [EXP_W-1:0]   exp_out_reg, exp_out_next;
    logic               out_free;
    logic               out_load;

    // class unit
    logic [1:0]         cu_st_reg, cu_st_next;
    logic [SC_W-1:0]    ci_reg, ci_next, cj_reg, cj_next;
    logic [FX_W-1:0]    cbx_reg, cbx_next, cby_reg, cby_next;
    logic [CNT_W-1:0]   nf_reg, nf_next, no_reg, no_next;
    logic [CNT_W-1:0]   nf_add, no_add;
    logic               rdv_reg, rdv_next;
    logic [CLS_W-1:0]   cu_res_reg, cu_res_next;
    logic               cu_start;
    logic [COORD_W-1:0] cu_x, cu_y;
    logic               cu_done;
    logic [FX_W-1:0]    fx, fy;

    // neighbor and query addressing
    logic [COORD_W-1:0] nx, ny;
    logic [VA_W-1:0]    nidx, qidx;
    logic               q_in;
    logic               pop;
    logic               push_ok;
    logic               adv_last;

    // memory ports
    logic                fine_we;
    logic [FA_W-1:0]     fine_waddr, fine_raddr;
    logic [CLS_W-1:0]    fine_wdata, fine_rdata;
    logic                vis_we;
    logic [VA_W-1:0]     vis_waddr, vis_raddr;
    logic                vis_wdata, vis_rdata;
    logic [2*CX_W-1:0]   stk_wdata, stk_rdata;
    logic [SA_W-1:0]     stk_raddr;

    always_comb
    begin
        priority if (int'(cfg.scale) < 2)
        begin
            eff_s = SC_W'(2);
        end
        else if (int'(cfg.scale) > MAX_SCALE)
        begin
            eff_s = SC_W'(MAX_SCALE);
        end
        else
        begin
            eff_s = SC_W'(cfg.scale);
        end
        eff_w = (int'(cfg.width) > COARSE_DIM) ? DIM_W'(COARSE_DIM) : DIM_W'(cfg.width);
        eff_h = (int'(cfg.height) > COARSE_DIM) ? DIM_W'(COARSE_DIM) : DIM_W'(cfg.height);
    end

    always_ff @(posedge clk)
    begin
        thr_reg <= thr_of(eff_s);
    end

    // neighbor coordinates, dx and dy codes 0..2 stand for -1..1
    assign nx   = cx_reg + COORD_W'(dx_reg) - COORD_W'(1);
    assign ny   = cy_reg + COORD_W'(dy_reg) - COORD_W'(1);
    assign nidx = VA_W'(ny[CX_W-1:0]) * VA_W'(COARSE_DIM) + VA_W'(nx[CX_W-1:0]);
    assign qidx = VA_W'(qy_reg[CX_W-1:0]) * VA_W'(COARSE_DIM) + VA_W'(qx_reg[CX_W-1:0]);
    assign q_in = in_map_f(COORD_W'(qx_reg), COORD_W'(qy_reg), eff_w, eff_h);

    assign out_free = !out_valid_reg || out_ready;
    assign q_ready  = (st_reg == S_IDLE) && out_free;
    assign pop      = q_valid && q_ready;
    assign clearing = (st_reg == S_RCLR);
    assign push_ok  = (st_reg == S_NVIS) && !vis_rdata && (sp_reg < SP_W'(STACK_DEPTH));
    assign adv_last = (dx_reg == 2'd2) && (dy_reg == 2'd2);

    // class unit: counts free and occupied fine cells of one coarse cell
    assign cu_done = (cu_st_reg == CU_OUT);
    assign fx      = cbx_reg + FX_W'(ci_reg);
    assign fy      = cby_reg + FX_W'(cj_reg);
    assign fine_raddr = FA_W'(fy) * FA_W'(FINE_DIM) + FA_W'(fx);
    assign nf_add  = nf_reg + CNT_W'(rdv_reg && (fine_rdata == CLS_FREE));
    assign no_add  = no_reg + CNT_W'(rdv_reg && (fine_rdata == CLS_OCC));

    always_comb
    begin
        unique case (st_reg)
            S_QCLS:
            begin
                cu_x = COORD_W'(qx_reg);
                cu_y = COORD_W'(qy_reg);
            end
            S_HSTART:
            begin
                cu_x = COORD_W'(cfg.home_x);
                cu_y = COORD_W'(cfg.home_y);
            end
            default:
            begin
                cu_x = nx;
                cu_y = ny;
            end
        endcase
        cu_start = (st_reg == S_QCLS) || (st_reg == S_HSTART) || (st_reg == S_NSTART);
    end

    always_comb
    begin
        cu_st_next  = cu_st_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        cbx_next    = cbx_reg;
        cby_next    = cby_reg;
        nf_next     = nf_add;
        no_next     = no_add;
        rdv_next    = 1'b0;
        cu_res_next = cu_res_reg;
        unique case (cu_st_reg)
            CU_IDLE:
            begin
                if (cu_start)
                begin
                    nf_next = '0;
                    no_next = '0;
                    if (in_map_f(cu_x, cu_y, eff_w, eff_h))
                    begin
                        cbx_next   = FX_W'(cu_x[CX_W-1:0]) * FX_W'(eff_s);
                        cby_next   = FX_W'(cu_y[CX_W-1:0]) * FX_W'(eff_s);
                        ci_next    = '0;
                        cj_next    = '0;
                        cu_st_next = CU_SCAN;
                    end
                    else
                    begin
                        cu_res_next = CLS_UNK;
                        cu_st_next  = CU_OUT;
                    end
                end
            end
            CU_SCAN:
            begin
                rdv_next = 1'b1;
                if (cj_reg == eff_s - SC_W'(1))
                begin
                    cj_next = '0;
                    if (ci_reg == eff_s - SC_W'(1))
                    begin
                        cu_st_next = CU_DRAIN;
                    end
                    else
                    begin
                        ci_next = ci_reg + SC_W'(1);
                    end
                end
                else
                begin
                    cj_next = cj_reg + SC_W'(1);
                end
            end
            CU_DRAIN:
            begin
                priority if (no_add > thr_reg)
                begin
                    cu_res_next = CLS_OCC;
                end
                else if (nf_add > thr_reg)
                begin
                    cu_res_next = CLS_FREE;
                end
                else
                begin
                    cu_res_next = CLS_UNK;
                end
                cu_st_next = CU_OUT;
            end
            default:
            begin
                cu_st_next = CU_IDLE;
            end
        endcase
    end

    // main sequencer
    always_comb
    begin
        st_next        = st_reg;
        clr_next       = clr_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        home_cls_next  = home_cls_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sp_next        = sp_reg;
        exp_next       = exp_reg;
        last_st_next   = last_st_reg;
        out_load       = 1'b0;
        status_next    = status_reg;
        reach_next     = reach_reg;
        cls_next       = cls_reg;
        exp_out_next   = exp_out_reg;
        fine_we        = 1'b0;
        fine_waddr     = FA_W'(q_cmd.py) * FA_W'(FINE_DIM) + FA_W'(q_cmd.px);
        fine_wdata     = q_cmd.fcls;
        vis_we         = 1'b0;
        vis_waddr      = nidx;
        vis_wdata      = 1'b1;
        vis_raddr      = nidx;
        unique case (st_reg)
            S_RCLR:
            begin
                fine_we    = 1'b1;
                fine_waddr = clr_reg;
                fine_wdata = CLS_UNK;
                vis_we     = (clr_reg < FA_W'(VIS_DEPTH));
                vis_waddr  = clr_reg[VA_W-1:0];
                vis_wdata  = 1'b0;
                clr_next   = clr_reg + FA_W'(1);
                if (clr_reg == FA_W'(FINE_DEPTH - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    qx_next = q_cmd.px;
                    qy_next = q_cmd.py;
                    unique case (q_cmd.mode)
                        MODE_WRITE:
                        begin
                            fine_we      = q_cmd.in_range;
                            out_load     = 1'b1;
                            status_next  = q_cmd.in_range ? STAT_OK : STAT_RANGE;
                            reach_next   = 1'b0;
                            cls_next     = CLS_FREE;
                            exp_out_next = exp_reg;
                        end
                        MODE_RUN:
                        begin
                            clr_next     = '0;
                            sp_next      = '0;
                            exp_next     = '0;
                            last_st_next = STAT_OK;
                            st_next      = S_VCLR;
                        end
                        MODE_QUERY:
                        begin
                            st_next = S_QCLS;
                        end
                        default:
                        begin
                            out_load     = 1'b1;
                            status_next  = last_st_reg;
                            reach_next   = 1'b0;
                            cls_next     = CLS_UNK;
                            exp_out_next = exp_reg;
                        end
                    endcase
                end
            end
            S_QCLS:
            begin
                vis_raddr = qidx;
                st_next   = S_QWAIT;
            end
            S_QWAIT:
            begin
                vis_raddr = qidx;
                if (cu_done)
                begin
                    out_load     = 1'b1;
                    status_next  = q_in ? STAT_OK : STAT_RANGE;
                    reach_next   = q_in && vis_rdata;
                    cls_next     = cu_res_reg;
                    exp_out_next = exp_reg;
                    st_next      = S_IDLE;
                end
            end
            S_VCLR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg[VA_W-1:0];
                vis_wdata = 1'b0;
                clr_next  = clr_reg + FA_W'(1);
                if (clr_reg == FA_W'(VIS_DEPTH - 1))
                begin
                    st_next = S_HSTART;
                end
            end
            S_HSTART:
            begin
                st_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (cu_done)
                begin
                    home_cls_next = cu_res_reg;
                    if (cu_res_reg == CLS_OCC)
                    begin
                        last_st_next = STAT_HOME_OCC;
                        st_next      = S_DONE;
                    end
                    else
                    begin
                        cx_next = COORD_W'(cfg.home_x);
                        cy_next = COORD_W'(cfg.home_y);
                        dx_next = '0;
                        dy_next = '0;
                        st_next = S_NSTART;
                    end
                end
            end
            S_NSTART:
            begin
                st_next = S_NWAIT;
            end
            S_NWAIT, S_NVIS:
            begin
                if (st_reg == S_NWAIT && cu_done && cu_res_reg == CLS_FREE)
                begin
                    st_next = S_NVIS;
                end
                else if (st_reg == S_NVIS || cu_done)
                begin
                    if (push_ok)
                    begin
                        vis_we  = 1'b1;
                        sp_next = sp_reg + SP_W'(1);
                    end
                    if (adv_last)
                    begin
                        st_next = S_POP;
                    end
                    else
                    begin
                        st_next = S_NSTART;
                        if (dy_reg == 2'd2)
                        begin
                            dy_next = '0;
                            dx_next = dx_reg + 2'd1;
                        end
                        else
                        begin
                            dy_next = dy_reg + 2'd1;
                        end
                    end
                end
            end
            S_POP:
            begin
                priority if (sp_reg == '0)
                begin
                    st_next = S_DONE;
                end
                else if (exp_reg >= cfg.max_exp)
                begin
                    last_st_next = STAT_LIMIT;
                    st_next      = S_DONE;
                end
                else
                begin
                    sp_next  = sp_reg - SP_W'(1);
                    exp_next = exp_reg + EXP_W'(1);
                    st_next  = S_PDATA;
                end
            end
            S_PDATA:
            begin
                cx_next = COORD_W'(stk_rdata[CX_W-1:0]);
                cy_next = COORD_W'(stk_rdata[2*CX_W-1:CX_W]);
                dx_next = '0;
                dy_next = '0;
                st_next = S_NSTART;
            end
            S_DONE:
            begin
                out_load     = 1'b1;
                status_next  = last_st_reg;
                reach_next   = 1'b0;
                cls_next     = home_cls_reg;
                exp_out_next = exp_reg;
                st_next      = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    assign stk_wdata = {ny[CX_W-1:0], nx[CX_W-1:0]};
    assign stk_raddr = SA_W'(sp_reg - SP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_RCLR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            exp_reg       <= '0;
            last_st_reg   <= STAT_OK;
            out_valid_reg <= 1'b0;
            cu_st_reg     <= CU_IDLE;
            rdv_reg       <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            exp_reg       <= exp_next;
            last_st_reg   <= last_st_next;
            out_valid_reg <= out_valid_next;
            cu_st_reg     <= cu_st_next;
            rdv_reg       <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        home_cls_reg <= home_cls_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        status_reg   <= status_next;
        reach_reg    <= reach_next;
        cls_reg      <= cls_next;
        exp_out_reg  <= exp_out_next;
        ci_reg       <= ci_next;
        cj_reg       <= cj_next;
        cbx_reg      <= cbx_next;
        cby_reg      <= cby_next;
        nf_reg       <= nf_next;
        no_reg       <= no_next;
        cu_res_reg   <= cu_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign reachable    = reach_reg;
    assign coarse_class = cls_reg;
    assign expanded     = exp_out_reg;

    cgff_ram #(
        .WIDTH(CLS_W),
        .DEPTH(FINE_DEPTH)
    ) u_fine_ram (
        .clk   (clk),
        .we    (fine_we),
        .waddr (fine_waddr),
        .wdata (fine_wdata),
        .raddr (fine_raddr),
        .rdata (fine_rdata)
    );

    cgff_ram #(
        .WIDTH(1),
        .DEPTH(VIS_DEPTH)
    ) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    cgff_ram #(
        .WIDTH(2 * CX_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (sp_reg[SA_W-1:0]),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule

// File: sv/coarse_grid_flood_fill.sv
// coarse_grid_flood_fill: top level, config registers, front decoder and back engine
// depends on cgff_pkg, cgff_front, cgff_back
// write, mode 3: front queue then result register; one per cycle with out_ready high
// query: the class unit reads the s*s fine cells of the coarse cell, one per cycle
// run: clear 4096 visited flags, then scan 9 neighbors of each expanded cell
// reset: clearing pass over all 65536 fine cells; no transaction accepted until done
module coarse_grid_flood_fill
    import cgff_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  mode,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [COST_W-1:0]  cost,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  status,
    output logic               reachable,
    output logic [CLS_W-1:0]   coarse_class,
    output logic [EXP_W-1:0]   expanded
);

    cfg_t cfg_reg;
    logic clearing;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale   <= SCALE_RST;
            cfg_reg.width   <= WH_RST;
            cfg_reg.height  <= WH_RST;
            cfg_reg.home_x  <= '0;
            cfg_reg.home_y  <= '0;
            cfg_reg.max_exp <= MAX_EXP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALE:   cfg_reg.scale   <= cfg_data[SCALE_W-1:0];
                CFG_WIDTH:   cfg_reg.width   <= cfg_data[WH_W-1:0];
                CFG_HEIGHT:  cfg_reg.height  <= cfg_data[WH_W-1:0];
                CFG_HOME_X:  cfg_reg.home_x  <= cfg_data[HOME_W-1:0];
                CFG_HOME_Y:  cfg_reg.home_y  <= cfg_data[HOME_W-1:0];
                CFG_MAX_EXP: cfg_reg.max_exp <= cfg_data[EXP_W-1:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    cgff_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .cost     (cost),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    cgff_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .reachable    (reachable),
        .coarse_class (coarse_class),
        .expanded     (expanded)
    );

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("transaction accepted during clearing pass");

    a_home_occ_no_expansion: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_HOME_OCC) |-> (expanded == '0))
        else $error("expansions counted on occupied home");

    a_reach_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reachable) |-> (status == STAT_OK))
        else $error("reachable flagged with non-ok status");

endmodule
